// ===== rtl/core/md5bc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and round tables for the MD5 block compression core.
// No dependencies; every other file of the core uses it by scoped names.
package md5bc_pkg;

    localparam int WORD_W          = 32;
    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS          = 64;
    localparam int WIDX_W          = $clog2(WORDS_PER_BLOCK);
    localparam int ROUND_W         = $clog2(ROUNDS);
    localparam int ROT_W           = 5;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [WIDX_W-1:0]  LAST_WORD  = WIDX_W'(WORDS_PER_BLOCK - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    // Round groups, selected by the two top bits of the round index
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_START,
        ST_ROUND,
        ST_FINISH,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic               write_word;
        logic               reload;
        logic               init_work;
        logic               round_en;
        logic               finish;
        logic [WIDX_W-1:0]  word_idx;
        logic [ROUND_W-1:0] round;
    } cmd_t;

    function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Left-rotate amount: four values per group, repeating every four rounds
    function automatic logic [ROT_W-1:0] rot_amount(input logic [ROUND_W-1:0] r);
        logic [ROT_W-1:0] s;
        case ({r[5:4], r[1:0]})
            4'b00_00: s = 5'd7;   4'b00_01: s = 5'd12;
            4'b00_10: s = 5'd17;  4'b00_11: s = 5'd22;
            4'b01_00: s = 5'd5;   4'b01_01: s = 5'd9;
            4'b01_10: s = 5'd14;  4'b01_11: s = 5'd20;
            4'b10_00: s = 5'd4;   4'b10_01: s = 5'd11;
            4'b10_10: s = 5'd16;  4'b10_11: s = 5'd23;
            4'b11_00: s = 5'd6;   4'b11_01: s = 5'd10;
            4'b11_10: s = 5'd15;  4'b11_11: s = 5'd21;
            default:  s = '0;
        endcase
        return s;
    endfunction

    // Message word order; only the low four bits of the round matter mod 16
    function automatic logic [WIDX_W-1:0] msg_index(input logic [ROUND_W-1:0] r);
        logic [WIDX_W-1:0] lo;
        logic [WIDX_W-1:0] g;
        lo = r[WIDX_W-1:0];
        case (r[5:4])
            GRP_F:   g = lo;
            GRP_G:   g = WIDX_W'(lo * WIDX_W'(5) + WIDX_W'(1));
            GRP_H:   g = WIDX_W'(lo * WIDX_W'(3) + WIDX_W'(5));
            GRP_I:   g = WIDX_W'(lo * WIDX_W'(7));
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/md5bc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the MD5 block compression core: word collection, rounds, delivery.
// Depends on md5bc_pkg for the state type and the command struct.
module md5bc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              new_message,
    output logic              out_valid,
    input  logic              out_stall,
    output md5bc_pkg::cmd_t   cmd
);

    md5bc_pkg::state_t                 state_reg, state_next;
    logic [md5bc_pkg::WIDX_W-1:0]      word_count_reg, word_count_next;
    logic [md5bc_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic                              in_beat;

    assign in_beat = (state_reg == md5bc_pkg::ST_COLLECT) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= md5bc_pkg::ST_COLLECT;
            word_count_reg <= '0;
            round_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            round_reg      <= round_next;
        end
    end

    // Next state and counters
    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        round_next      = round_reg;
        case (state_reg)
            md5bc_pkg::ST_COLLECT:
            begin
                if (in_beat)
                begin
                    word_count_next = word_count_reg + 1'b1;
                    if (word_count_reg == md5bc_pkg::LAST_WORD)
                        state_next = md5bc_pkg::ST_START;
                end
            end
            md5bc_pkg::ST_START:
            begin
                round_next = '0;
                state_next = md5bc_pkg::ST_ROUND;
            end
            md5bc_pkg::ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == md5bc_pkg::LAST_ROUND)
                    state_next = md5bc_pkg::ST_FINISH;
            end
            md5bc_pkg::ST_FINISH:
            begin
                state_next = md5bc_pkg::ST_DELIVER;
            end
            md5bc_pkg::ST_DELIVER:
            begin
                if (!out_stall)
                    state_next = md5bc_pkg::ST_COLLECT;
            end
            default:
            begin
                state_next = md5bc_pkg::ST_COLLECT;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        cmd.write_word = 1'b0;
        cmd.reload     = 1'b0;
        cmd.init_work  = 1'b0;
        cmd.round_en   = 1'b0;
        cmd.finish     = 1'b0;
        cmd.word_idx   = word_count_reg;
        cmd.round      = round_reg;
        case (state_reg)
            md5bc_pkg::ST_COLLECT:
            begin
                in_stall       = 1'b0;
                cmd.write_word = in_beat;
                cmd.reload     = in_beat && new_message;
            end
            md5bc_pkg::ST_START:   cmd.init_work = 1'b1;
            md5bc_pkg::ST_ROUND:   cmd.round_en  = 1'b1;
            md5bc_pkg::ST_FINISH:  cmd.finish    = 1'b1;
            md5bc_pkg::ST_DELIVER: out_valid     = 1'b1;
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5bc_pkg::ST_START) |-> (word_count_reg == '0))
        else $error("block started with words still counted");

    a_round_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5bc_pkg::ST_START) |=> (round_reg == '0))
        else $error("rounds did not start from zero");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5bc_pkg::ST_ROUND && round_reg == md5bc_pkg::LAST_ROUND)
        |=> (state_reg == md5bc_pkg::ST_FINISH))
        else $error("last round not followed by finish");

    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && word_count_reg == md5bc_pkg::LAST_WORD)
        |=> (state_reg == md5bc_pkg::ST_START))
        else $error("sixteenth word did not start compression");

endmodule

// ===== rtl/core/md5bc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the MD5 block compression core: block buffer, working and chaining registers.
// Depends on md5bc_pkg for tables, constants and the command struct.
module md5bc_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  md5bc_pkg::cmd_t                   cmd,
    input  logic [md5bc_pkg::WORD_W-1:0]      message_word,
    output logic [md5bc_pkg::WORD_W-1:0]      chain_a,
    output logic [md5bc_pkg::WORD_W-1:0]      chain_b,
    output logic [md5bc_pkg::WORD_W-1:0]      chain_c,
    output logic [md5bc_pkg::WORD_W-1:0]      chain_d
);

    localparam int W = md5bc_pkg::WORD_W;

    logic [W-1:0] buf_mem [md5bc_pkg::WORDS_PER_BLOCK];

    logic [W-1:0] ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [W-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [W-1:0] pre_reg, pre_next;   // a + K + M of the round about to run

    logic [md5bc_pkg::ROUND_W-1:0] pre_round;
    logic [W-1:0]                  pre_a;
    logic [W-1:0]                  f_val;
    logic [W-1:0]                  sum;
    logic [2*W-1:0]                rot_dbl;
    logic [W-1:0]                  b_next;

    always_ff @(posedge clk)
    begin
        if (cmd.write_word)
            buf_mem[cmd.word_idx] <= message_word;
    end

    // Prefetch the next round's addend into pre_reg, ahead of its round
    always_comb
    begin
        pre_round = cmd.init_work ? '0 : cmd.round + 1'b1;
        pre_a     = cmd.init_work ? ch_a_reg : wd_reg;
        pre_next  = pre_a + md5bc_pkg::round_const(pre_round)
                  + buf_mem[md5bc_pkg::msg_index(pre_round)];
    end

    always_comb
    begin
        case (cmd.round[5:4])
            md5bc_pkg::GRP_F: f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            md5bc_pkg::GRP_G: f_val = (wb_reg & wd_reg) | (wc_reg & ~wd_reg);
            md5bc_pkg::GRP_H: f_val = wb_reg ^ wc_reg ^ wd_reg;
            md5bc_pkg::GRP_I: f_val = wc_reg ^ (wb_reg | ~wd_reg);
            default:          f_val = '0;
        endcase
        sum     = f_val + pre_reg;
        rot_dbl = {sum, sum} << md5bc_pkg::rot_amount(cmd.round);
        b_next  = wb_reg + rot_dbl[2*W-1:W];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_work || cmd.round_en)
            pre_reg <= pre_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wa_reg <= '0;
            wb_reg <= '0;
            wc_reg <= '0;
            wd_reg <= '0;
        end
        else if (cmd.init_work)
        begin
            wa_reg <= ch_a_reg;
            wb_reg <= ch_b_reg;
            wc_reg <= ch_c_reg;
            wd_reg <= ch_d_reg;
        end
        else if (cmd.round_en)
        begin
            wa_reg <= wd_reg;
            wd_reg <= wc_reg;
            wc_reg <= wb_reg;
            wb_reg <= b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_a_reg <= md5bc_pkg::IV_A;
            ch_b_reg <= md5bc_pkg::IV_B;
            ch_c_reg <= md5bc_pkg::IV_C;
            ch_d_reg <= md5bc_pkg::IV_D;
        end
        else if (cmd.reload)
        begin
            ch_a_reg <= md5bc_pkg::IV_A;
            ch_b_reg <= md5bc_pkg::IV_B;
            ch_c_reg <= md5bc_pkg::IV_C;
            ch_d_reg <= md5bc_pkg::IV_D;
        end
        else if (cmd.finish)
        begin
            ch_a_reg <= ch_a_reg + wa_reg;
            ch_b_reg <= ch_b_reg + wb_reg;
            ch_c_reg <= ch_c_reg + wc_reg;
            ch_d_reg <= ch_d_reg + wd_reg;
        end
    end

    assign chain_a = ch_a_reg;
    assign chain_b = ch_b_reg;
    assign chain_c = ch_c_reg;
    assign chain_d = ch_d_reg;

endmodule

// ===== rtl/core/md5_block_compression_top.sv =====
`timescale 1ns / 1ps
// Top level of the MD5 block compression core: sequencer plus datapath.
// Depends on md5bc_pkg, md5bc_ctrl and md5bc_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_stall    | message_word[31:0], new_message
//   out     | out_valid / out_stall  | chain_a, chain_b, chain_c, chain_d
//
// Sixteen words are taken one beat per cycle while in_stall is low; the
// sixteenth starts a block. The block then passes one prefetch step, 64
// rounds through the single round unit and one chaining add before the
// result is shown.
// Reset loads the MD5 initial value and empties the word count.
// in_stall is high from the closing word until the result beat is taken;
// out_stall holds the result on the ports for as long as it stays high.
module md5_block_compression_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] message_word,
    input  logic        new_message,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] chain_a,
    output logic [31:0] chain_b,
    output logic [31:0] chain_c,
    output logic [31:0] chain_d
);

    // Commands from the sequencer; the datapath only obeys them
    md5bc_pkg::cmd_t cmd;

    md5bc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .new_message (new_message),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    // Chaining registers drive the result ports directly; they hold still
    // while the result beat waits since the input side is stalled then.
    md5bc_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .chain_a      (chain_a),
        .chain_b      (chain_b),
        .chain_c      (chain_c),
        .chain_d      (chain_d)
    );

endmodule

// ===== dv/tb_md5_block_compression_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for md5_block_compression_top: a scoreboard class predicts
// the chaining value after every sixteen-word block, plain tasks feed the core.
// Depends only on the RTL top; the predictor keeps its own MD5 tables.
module tb_md5_block_compression_top;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int WORDS_IN_BLOCK = 16;
    localparam int RANDOM_BLOCKS  = 122;   // 16 directed + 1952 random words
    localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
    localparam int DRAIN_CYCLES   = 120;   // well past the block latency
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side

    // Digest predictor and result store. One entry is queued per closing word;
    // every result beat is checked against the oldest entry.
    class md5_chain_scoreboard;
        logic [31:0]  chain_value [4];
        logic [31:0]  block_words [16];
        logic [31:0]  sine_k [64];
        int unsigned  rot_by [16];
        string        field_name [4];
        int unsigned  fill;
        logic [127:0] digests_due [$];
        int unsigned  words_seen;
        int unsigned  reloads_seen;
        int unsigned  digests_checked;
        int unsigned  mismatches;

        function new();
            sine_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
            };
            // four rotate amounts per round group, repeating every four rounds
            rot_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            field_name = '{"chain_a", "chain_b", "chain_c", "chain_d"};
            load_initial_value();
            fill            = 0;
            words_seen      = 0;
            reloads_seen    = 0;
            digests_checked = 0;
            mismatches      = 0;
        endfunction

        function void load_initial_value();
            chain_value = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        endfunction

        // Run the 64 rounds over the gathered block and fold into the chain.
        function void compress_block();
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            logic [31:0] d;
            logic [31:0] f;
            logic [31:0] sum;
            int unsigned g;
            int unsigned sh;
            a = chain_value[0];
            b = chain_value[1];
            c = chain_value[2];
            d = chain_value[3];
            for (int r = 0; r < 64; r++)
            begin
                case (r / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * r + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                sum = f + a + sine_k[r] + block_words[g];
                sh  = rot_by[(r / 16) * 4 + r % 4];
                a   = d;
                d   = c;
                c   = b;
                b   = b + ((sum << sh) | (sum >> (32 - sh)));
            end
            chain_value[0] += a;
            chain_value[1] += b;
            chain_value[2] += c;
            chain_value[3] += d;
        endfunction

        // Note one accepted input beat; queue a digest on the closing word.
        function void note_word(logic [31:0] word, logic reload);
            words_seen++;
            if (reload)
            begin
                reloads_seen++;
                load_initial_value();
            end
            block_words[fill] = word;
            fill++;
            if (fill == WORDS_IN_BLOCK)
            begin
                fill = 0;
                compress_block();
                digests_due.push_back({chain_value[0], chain_value[1],
                                       chain_value[2], chain_value[3]});
            end
        endfunction

        // Check one accepted result beat against the oldest queued digest.
        function void check_digest(logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c, logic [31:0] d);
            logic [127:0] due;
            logic [31:0]  got [4];
            logic [31:0]  want;
            if (digests_due.size() == 0)
            begin
                mismatches++;
                $error("result beat %h %h %h %h with no digest pending", a, b, c, d);
                return;
            end
            due = digests_due.pop_front();
            got = '{a, b, c, d};
            digests_checked++;
            for (int i = 0; i < 4; i++)
            begin
                want = due[127 - 32 * i -: 32];
                if (got[i] !== want)
                begin
                    mismatches++;
                    $error("%s: expected %h, got %h", field_name[i], want, got[i]);
                end
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [31:0] message_word = '0;
    logic        new_message  = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [31:0] chain_a;
    logic [31:0] chain_b;
    logic [31:0] chain_c;
    logic [31:0] chain_d;

    // When set, neither side idles: back-to-back beats for a whole block.
    bit          steady       = 1'b0;
    int unsigned quiet_cycles = 0;

    md5_chain_scoreboard scoreboard = new();

    md5_block_compression_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .new_message  (new_message),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chain_a      (chain_a),
        .chain_b      (chain_b),
        .chain_c      (chain_c),
        .chain_d      (chain_d)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Offer one word, after an optional gap, and hold it until the core takes it.
    // Called right after a rising edge; returns at the edge that accepts the beat.
    task automatic send_word(input logic [31:0] word, input logic reload);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= word;
        new_message  <= reload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Sample both channels at the edge. Inputs were driven by nonblocking
    // assignments and core outputs settle after the edge, so the values read
    // here are the ones that stood before it.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            scoreboard.note_word(message_word, new_message);
        if (out_valid && !out_stall)
            scoreboard.check_digest(chain_a, chain_b, chain_c, chain_d);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: stall at random, independent of out_valid. Once a dozen
    // digests are in, hold off for a long stretch so that the core keeps its
    // result waiting and backs up the sender through in_stall.
    initial
    begin : result_taker
        int unsigned hold;
        bit          held_off;
        held_off = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held_off && scoreboard.digests_checked >= 12)
            begin
                held_off = 1'b1;
                hold     = HOLD_CYCLES;
            end
            else
                hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // End the run if no beat moves on either side for too long.
    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no beat for %0d cycles, %0d digests still due",
                 WATCHDOG_LIMIT, scoreboard.digests_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned msg_blocks_left;
        int unsigned roll;
        bit          fresh;
        logic [31:0] word;
        logic        reload;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed block: start from the reset chaining value, all-zero and
        // all-one words plus alternating bit patterns; reload once in mid
        // block (earlier words must survive) and again on the closing word.
        for (int k = 0; k < WORDS_IN_BLOCK; k++)
        begin
            case (k)
                0:       word = 32'h0000_0000;
                1:       word = 32'hffff_ffff;
                default: word = k[0] ? 32'haaaa_aaaa : 32'h5555_5555;
            endcase
            send_word(word, (k == 3) || (k == WORDS_IN_BLOCK - 1));
        end

        // Random part: messages of one to four chained blocks, each opened by
        // a reload on its first word, with stray reloads anywhere as noise.
        msg_blocks_left = 0;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            steady = ($urandom_range(3) == 0);
            fresh  = (msg_blocks_left == 0);
            if (fresh)
                msg_blocks_left = $urandom_range(4, 1);
            msg_blocks_left--;
            for (int k = 0; k < WORDS_IN_BLOCK; k++)
            begin
                roll = $urandom_range(9);
                case (roll)
                    0:       word = 32'h0000_0000;
                    1:       word = 32'hffff_ffff;
                    2:       word = 32'h1 << $urandom_range(31);
                    default: word = $urandom();
                endcase
                reload = (fresh && k == 0) || ($urandom_range(39) == 0);
                send_word(word, reload);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every queued digest, then watch for stray beats.
        while (scoreboard.digests_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d message words through %0d checked blocks, %0d with reload.",
                 scoreboard.words_seen, scoreboard.digests_checked,
                 scoreboard.reloads_seen);
        $display("Random idling on both sides plus one %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (scoreboard.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
